// ===== hw/rtl/wflm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wflm_pkg
// Shared types and constants for the windowed frame loss monitor.
// ----------------------------------------------------------------------------
package wflm_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF = 32;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_FORGET = 2'd2;

  localparam logic [1:0] CFG_IDX_WINDOW = 2'd0;
  localparam logic [1:0] CFG_IDX_ALARM  = 2'd1;

  localparam logic [31:0] WINDOW_MS_RST = 32'd5000;
  localparam logic [6:0]  ALARM_PCT_RST = 7'd20;
  localparam logic [6:0]  PCT_SCALE     = 7'd100;
  localparam int unsigned QUO_BITS      = 7;

  typedef struct packed {
    logic [31:0] tstamp;
    logic        ok;
  } sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

// ===== hw/rtl/windowed_frame_loss_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_frame_loss_monitor
// Frame loss percentage over a sliding time window of recent samples.
// ----------------------------------------------------------------------------
// A query scans the filled entries with one memory read per cycle, then runs a
// 7-step restoring divider and loads the output register.
// One item is in work at a time; the output register frees the input side.
// Reset (async, active low) empties the sample ring, drops the remembered
// percentage and loads window_ms = 5000 and alarm_pct = 20. No clearing pass.
module windowed_frame_loss_monitor
  import wflm_pkg::*;
#(
  parameter int unsigned SampleDepth = SAMPLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] time_ms_i,
  input  logic        parsed_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  loss_pct_o,
  output logic        pct_changed_o,
  output logic        high_loss_o
);

  localparam int unsigned AW = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
  localparam int unsigned CW = $clog2(SampleDepth + 1);
  localparam int unsigned NW = CW + QUO_BITS;

  state_e state_q, state_d;

  logic [31:0] window_q;
  logic [6:0]  alarm_q;

  sample_t mem [SampleDepth];
  sample_t rd_q;
  logic    rd_vld_q;

  logic [AW-1:0] wr_ptr_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] scan_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] failed_q;
  logic [31:0]   now_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] dvs_q;
  logic [6:0]    quo_q;
  logic [2:0]    step_q;

  logic       lr_valid_q;
  logic [6:0] lr_val_q;

  logic       out_valid_q;
  logic [6:0] loss_pct_q;
  logic       pct_changed_q;
  logic       high_loss_q;

  logic in_acc;
  logic rec_acc;
  logic issue;
  logic out_free;
  logic age_ok;
  logic div_ge;
  logic [6:0] pct;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign rec_acc  = in_acc && (op_i == OP_RECORD);
  assign issue    = (state_q == ST_SCAN) && (scan_q < fill_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign age_ok   = (now_q - rd_q.tstamp) <= window_q;
  assign div_ge   = rem_q >= dvs_q;
  assign pct      = (total_q == '0) ? (lr_valid_q ? lr_val_q : 7'd0) : quo_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && op_i == OP_QUERY) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !rd_vld_q) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == 3'(QUO_BITS - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN, ST_MUL, ST_DIV, ST_FIN: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      mem[wr_ptr_q] <= '{tstamp: time_ms_i, ok: parsed_ok_i};
    end
    if (issue) begin
      rd_q <= mem[scan_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      window_q      <= WINDOW_MS_RST;
      alarm_q       <= ALARM_PCT_RST;
      wr_ptr_q      <= '0;
      fill_q        <= '0;
      rd_vld_q      <= 1'b0;
      lr_valid_q    <= 1'b0;
      lr_val_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WINDOW: window_q <= cfg_data_i;
          CFG_IDX_ALARM:  alarm_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (rec_acc) begin
        wr_ptr_q <= (wr_ptr_q == AW'(SampleDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
        if (fill_q != CW'(SampleDepth)) fill_q <= fill_q + 1'b1;
      end
      if (in_acc && op_i == OP_FORGET) lr_valid_q <= 1'b0;
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        lr_valid_q  <= 1'b1;
        lr_val_q    <= pct;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op_i == OP_QUERY) begin
      now_q    <= time_ms_i;
      scan_q   <= '0;
      total_q  <= '0;
      failed_q <= '0;
    end
    if (issue) scan_q <= scan_q + 1'b1;
    if (rd_vld_q && age_ok) begin
      total_q <= total_q + 1'b1;
      if (!rd_q.ok) failed_q <= failed_q + 1'b1;
    end
    if (state_q == ST_MUL) begin
      rem_q  <= NW'(failed_q) * NW'(PCT_SCALE);
      dvs_q  <= NW'({total_q, 6'b0});
      quo_q  <= '0;
      step_q <= '0;
    end
    if (state_q == ST_DIV) begin
      if (div_ge) rem_q <= rem_q - dvs_q;
      dvs_q  <= dvs_q >> 1;
      quo_q  <= {quo_q[5:0], div_ge};
      step_q <= step_q + 1'b1;
    end
    if (state_q == ST_FIN && out_free) begin
      loss_pct_q    <= pct;
      pct_changed_q <= !lr_valid_q || (lr_val_q != pct);
      high_loss_q   <= pct >= alarm_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign loss_pct_o    = loss_pct_q;
  assign pct_changed_o = pct_changed_q;
  assign high_loss_o   = high_loss_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(SampleDepth))
    else $error("fill count above depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q <= fill_q))
    else $error("scan pointer past filled entries");

  a_query_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i == OP_QUERY) |=> (state_q == ST_SCAN))
    else $error("query did not start a scan");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished query not presented");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (loss_pct_q <= PCT_SCALE))
    else $error("loss percentage above one hundred");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed frame loss monitor. A behavioral
// model of the sample ring and the loss percentage is updated for every
// item the block accepts, and every result is compared field by field.
// The run starts with directed items for the empty window, forget, the
// unused op code, wrapping ages, register extremes and one long output
// hold-off that backs up the input. Random traffic then runs under several
// window and alarm settings, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import wflm_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam int unsigned RING_DEPTH       = SAMPLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned QUIET_CYCLES     = 60;
  localparam int unsigned PHASE_ITEMS      = 250;

  typedef struct packed {
    logic [6:0] loss_pct;
    logic       changed;
    logic       high;
  } loss_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_IDX_WINDOW;
  logic [31:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i          = OP_RECORD;
  logic [31:0] time_ms_i     = '0;
  logic        parsed_ok_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [6:0]  loss_pct_o;
  logic        pct_changed_o;
  logic        high_loss_o;

  // model state
  logic [31:0] ring_time [RING_DEPTH];
  logic        ring_ok   [RING_DEPTH];
  int unsigned ring_slot    = 0;
  int unsigned ring_filled  = 0;
  int          last_pct     = -1;
  logic [31:0] win_ms       = WINDOW_MS_RST;
  logic [6:0]  alarm_pct    = ALARM_PCT_RST;

  loss_report_t pending_reports[$];
  loss_report_t head_report;

  // traffic control
  logic [31:0] now_ms     = '0;
  int unsigned burst_left = 0;
  logic        gaps_on    = 1'b1;
  logic        stall_on   = 1'b1;
  int unsigned hold_req   = 0;
  int unsigned hold_left  = 0;
  logic [31:0] stall_pat  = '0;
  logic [4:0]  stall_tick = '0;

  int unsigned err_count       = 0;
  int unsigned items_accepted  = 0;
  int unsigned reports_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned cycle_count     = 0;

  windowed_frame_loss_monitor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .time_ms_i    (time_ms_i),
    .parsed_ok_i  (parsed_ok_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .loss_pct_o   (loss_pct_o),
    .pct_changed_o(pct_changed_o),
    .high_loss_o  (high_loss_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic update_loss_model(input logic [1:0] op, input logic [31:0] t,
                                   input logic ok);
    int unsigned  total;
    int unsigned  failed;
    int unsigned  pct;
    int unsigned  i;
    logic [31:0]  age;
    loss_report_t rep;
    total  = 0;
    failed = 0;
    case (op)
      OP_RECORD: begin
        ring_time[ring_slot] = t;
        ring_ok[ring_slot]   = ok;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        if (ring_filled < RING_DEPTH) ring_filled++;
      end
      OP_FORGET: begin
        last_pct = -1;
      end
      OP_QUERY: begin
        for (i = 0; i < ring_filled; i++) begin
          age = t - ring_time[i];
          if (age <= win_ms) begin
            total++;
            if (!ring_ok[i]) failed++;
          end
        end
        if (total == 0) pct = (last_pct < 0) ? 0 : last_pct;
        else pct = (failed * 100) / total;
        rep.loss_pct = pct[6:0];
        rep.changed  = (last_pct < 0) || (last_pct != int'(pct));
        rep.high     = (pct >= alarm_pct);
        last_pct = int'(pct);
        pending_reports.push_back(rep);
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_writes++;
        case (cfg_idx_i)
          CFG_IDX_WINDOW: win_ms = cfg_data_i;
          CFG_IDX_ALARM:  alarm_pct = cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        items_accepted++;
        update_loss_model(op_i, time_ms_i, parsed_ok_i);
      end
      if (in_valid_i && in_stall_o) in_stall_cycles++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing expected, loss_pct", int'(loss_pct_o), 0);
      end else begin
        head_report = pending_reports.pop_front();
        reports_checked++;
        if (loss_pct_o !== head_report.loss_pct)
          report_mismatch("loss_pct", int'(loss_pct_o), int'(head_report.loss_pct));
        if (pct_changed_o !== head_report.changed)
          report_mismatch("pct_changed", int'(pct_changed_o), int'(head_report.changed));
        if (high_loss_o !== head_report.high)
          report_mismatch("high_loss", int'(high_loss_o), int'(head_report.high));
      end
    end
  end

  // receiver: random stall pattern, or a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (stall_tick == 0)
        stall_pat = $urandom_range(0, 1) ? $urandom : ($urandom & $urandom);
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = stall_on && stall_pat[stall_tick];
      end
      stall_tick++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("windowed_frame_loss_monitor test failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] t, input logic ok);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  = 1'b1;
    op_i        = op;
    time_ms_i   = t;
    parsed_ok_i = ok;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic test_idle_queries();
    send_item(OP_QUERY, 32'h0000_0000, 1'b0);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_FORGET, 32'h0000_0000, 1'b0);
    send_item(OP_QUERY, 32'd100, 1'b0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_QUERY, 32'd100, 1'b1);
    wait_quiet();
  endtask

  task automatic test_wrapping_ages();
    send_item(OP_RECORD, 32'hFFFF_FFF0, 1'b0);
    send_item(OP_RECORD, 32'h0000_0010, 1'b1);
    send_item(OP_QUERY, 32'h0000_0020, 1'b0);
    send_item(OP_RECORD, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_RECORD, 32'h0000_0000, 1'b1);
    send_item(OP_QUERY, 32'h0000_0000, 1'b1);
    // everything aged out: last percentage repeats
    send_item(OP_QUERY, 32'h8000_0000, 1'b0);
    wait_quiet();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_IDX_WINDOW, 32'h0000_0000);
    send_item(OP_RECORD, 32'd1234, 1'b0);
    send_item(OP_QUERY, 32'd1234, 1'b0);
    send_item(OP_QUERY, 32'd1235, 1'b0);
    wait_quiet();
    write_reg(CFG_IDX_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_ALARM, 32'd0);
    send_item(OP_QUERY, 32'h5555_5555, 1'b0);
    wait_quiet();
    write_reg(CFG_IDX_ALARM, 32'd101);
    send_item(OP_QUERY, 32'h5555_5555, 1'b1);
    wait_quiet();
    write_reg(CFG_IDX_ALARM, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'h0000_0000, 1'b0);
    wait_quiet();
    write_reg(CFG_IDX_ALARM, 32'd100);
    write_reg(CFG_IDX_WINDOW, 32'h0000_0000);
    send_item(OP_RECORD, 32'd77, 1'b0);
    send_item(OP_QUERY, 32'd77, 1'b0);
    wait_quiet();
    // writes to unused indexes must leave both registers alone
    write_reg(CFG_IDX_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_SPARE_B, 32'h0000_0000);
    send_item(OP_QUERY, 32'd77, 1'b1);
    wait_quiet();
  endtask

  task automatic run_traffic(input int unsigned n_items, input logic [31:0] win);
    logic [31:0] step_max;
    int unsigned fail_pct;
    int unsigned pick;
    int unsigned i;
    step_max = win / 6;
    if (step_max == 0) step_max = 1;
    fail_pct = $urandom_range(0, 100);
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        now_ms = now_ms + $urandom_range(0, step_max);
        send_item(OP_RECORD, now_ms, $urandom_range(0, 99) >= fail_pct);
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) now_ms = now_ms + step_max * 8;
        send_item(OP_QUERY, now_ms + $urandom_range(0, step_max),
                  1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        send_item(OP_FORGET, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 91) begin
        send_item(OP_UNUSED, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        send_item(OP_RECORD, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_QUERY, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_output_holdoff();
    int unsigned i;
    write_reg(CFG_IDX_WINDOW, WINDOW_MS_RST);
    write_reg(CFG_IDX_ALARM, {25'd0, ALARM_PCT_RST});
    wait_quiet();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    hold_req = 400;
    for (i = 0; i < 40; i++) begin
      if (i % 2 == 0) begin
        now_ms = now_ms + 10;
        send_item(OP_RECORD, now_ms, (i % 3) != 0);
      end else begin
        send_item(OP_QUERY, now_ms, 1'b0);
      end
    end
    wait_quiet();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [31:0] win;
    logic [6:0]  alarm;
    int unsigned p;
    for (p = 0; p < 8; p++) begin
      wait_quiet();
      case (p)
        0: begin win = 32'd5000;      alarm = 7'd20;  end
        1: begin win = 32'd1;         alarm = 7'd0;   end
        2: begin win = 32'd0;         alarm = 7'd100; end
        3: begin win = 32'hFFFF_FFFF; alarm = 7'd127; end
        4: begin win = 32'd100;       alarm = 7'd101; end
        5: begin win = 32'd65535;     alarm = 7'd50;  end
        6: begin win = 32'd300;       alarm = 7'd33;  end
        default: begin
          win   = $urandom;
          alarm = 7'($urandom_range(0, 127));
        end
      endcase
      write_reg(CFG_IDX_WINDOW, win);
      write_reg(CFG_IDX_ALARM, {25'd0, alarm});
      now_ms   = (p % 3 == 0) ? 32'hFFFF_FF00 : $urandom;
      gaps_on  = (p != 2);
      stall_on = (p != 2);
      run_traffic(PHASE_ITEMS, win);
    end
    wait_quiet();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_queries();
    test_wrapping_ages();
    test_register_extremes();
    test_output_holdoff();
    test_random_phases();
    wait_quiet();
    $display("Summary: %0d items accepted, %0d loss reports checked, %0d register writes",
             items_accepted, reports_checked, cfg_writes);
    $display("Windows from 0 to max with wrapping time, alarm 0 to 127, input stalled %0d cycles",
             in_stall_cycles);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("windowed_frame_loss_monitor test passed");
    end else begin
      $display("windowed_frame_loss_monitor test failed");
    end
    $finish;
  end

endmodule
